### hw/rtl/i2c_mts_pkg.sv
package i2c_mts_pkg;

  localparam int MAX_MESSAGES = 4;
  localparam int MSG_IW       = $clog2(MAX_MESSAGES);
  localparam int STORE_DEPTH  = 256;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);

  localparam logic [9:0] ST_WR_FULL  = 10'h001;
  localparam logic [9:0] ST_RD_FULL  = 10'h002;
  localparam logic [9:0] ST_ERRORS   = 10'h0fc;
  localparam logic [9:0] WORD_ADDR   = 10'h100;
  localparam logic [9:0] WORD_LAST   = 10'h200;

  typedef enum logic [1:0] {
    FUNC_LOAD_DESC = 2'd0,
    FUNC_LOAD_BYTE = 2'd1,
    FUNC_START     = 2'd2,
    FUNC_STATUS    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OUTC_RUNNING = 2'd0,
    OUTC_DONE    = 2'd1,
    OUTC_ERROR   = 2'd2,
    OUTC_IDLE    = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [7:0] len;
    logic       rd;
    logic [6:0] addr;
  } desc_t;

  typedef struct packed {
    logic [7:0] read_byte_in;
    logic [9:0] ctrl_status;
    logic [2:0] msg_count;
    logic [7:0] write_byte;
    logic [7:0] byte_index;
    logic [7:0] msg_len;
    logic       msg_read;
    logic [6:0] msg_addr;
    logic [1:0] msg_index;
  } in_item_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [1:0] read_message;
    logic [7:0] read_position;
    logic [7:0] read_data;
    logic       read_valid;
    logic       stop_write;
    logic [9:0] data_write_word;
    logic       data_write_valid;
  } result_t;

endpackage

### hw/rtl/i2c_mts_ram.sv
module i2c_mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/i2c_master_transfer_sequencer.sv
// Channel  Direction  Payload                                    Side band
// in_      slave      descriptor, write byte, start, status      tuser = func
// out_     master     write word, stop, read byte, outcome       none
//
// Every item is processed in the cycle it is accepted; its result is registered for out_,
// via the skid entry on a stall; one item per cycle is sustained while out_tready is high.
// The write store RAM is read ahead at the next write pointer, so a
// status item finds its next data byte ready; a write to that entry is forwarded.
// An output register and one skid entry let one more item in while out_tready is low.
// in_tready is low while the skid entry is full, including the cycle in which it
// moves to the output register. Reset clears control state only.
module i2c_master_transfer_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: msg_index, msg_addr, msg_read, msg_len, byte_index,
  // write_byte, msg_count, ctrl_status, read_byte_in, zero pad.
  input  logic [55:0] in_tdata,
  // Fields from bit 0: func.
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: data_write_valid, data_write_word, stop_write,
  // read_valid, read_data, read_position, read_message, outcome, zero pad.
  output logic [39:0] out_tdata
);

  import i2c_mts_pkg::*;

  in_item_t             item;
  func_t                func;
  logic                 in_acc;
  result_t              res;

  desc_t                desc_r [MAX_MESSAGES];
  desc_t                d;
  logic [MSG_IW-1:0]    desc_sel;
  logic                 desc_we;

  logic                 active_r, active_nxt;
  logic [MSG_IW-1:0]    cm_r, cm_nxt;
  logic [2:0]           ml_r, ml_nxt;
  logic                 ap_r, ap_nxt;
  logic [7:0]           bp_r, bp_nxt;
  logic [7:0]           bl_r, bl_nxt;
  logic                 len_pend_r, len_pend_nxt;
  logic [STORE_AW-1:0]  wp_r, wp_nxt;
  logic                 fp_r, fp_nxt;
  logic [7:0]           fc_r, fc_nxt;

  logic                 ram_we;
  logic [STORE_AW-1:0]  ram_raddr;
  logic [7:0]           ram_rdata;
  logic                 fwd_r;
  logic [7:0]           fwd_data_r;
  logic [7:0]           st_byte;

  logic                 out_valid_r;
  result_t              out_data_r;
  logic                 skid_valid_r;
  result_t              skid_data_r;

  assign item      = in_item_t'(in_tdata[54:0]);
  assign func      = func_t'(in_tuser);
  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign desc_sel  = (in_acc && func == FUNC_START) ? '0 : cm_r;
  assign d         = desc_r[desc_sel];
  assign st_byte   = fwd_r ? fwd_data_r : ram_rdata;
  assign ram_raddr = rst_n ? wp_nxt : '0;

  i2c_mts_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (item.byte_index[STORE_AW-1:0]),
    .wr_data (item.write_byte),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    logic       act;
    logic [2:0] ml;
    logic       ap;
    logic [7:0] bp;
    logic [7:0] bl;
    logic       fp;
    logic [7:0] fc;
    logic       more_to_send;
    logic [2:0] n;
    logic [9:0] w;

    active_nxt   = active_r;
    cm_nxt       = cm_r;
    ml_nxt       = ml_r;
    ap_nxt       = ap_r;
    bp_nxt       = bp_r;
    bl_nxt       = bl_r;
    len_pend_nxt = len_pend_r;
    wp_nxt       = wp_r;
    fp_nxt       = fp_r;
    fc_nxt       = fc_r;
    desc_we      = 1'b0;
    ram_we       = 1'b0;
    res          = '0;
    act          = active_r;
    ml           = ml_r;
    ap           = ap_r;
    bp           = bp_r;
    bl           = len_pend_r ? d.len : bl_r;
    fp           = fp_r;
    fc           = fc_r;
    more_to_send = 1'b1;
    n            = item.msg_count;
    w            = '0;

    if (in_acc) begin
      case (func)
        FUNC_LOAD_DESC: begin
          desc_we = 1'b1;
          if (len_pend_r) begin
            bl_nxt       = d.len;
            len_pend_nxt = 1'b0;
          end
          res.outcome = active_r ? OUTC_RUNNING : OUTC_IDLE;
        end
        FUNC_LOAD_BYTE: begin
          ram_we      = 1'b1;
          res.outcome = active_r ? OUTC_RUNNING : OUTC_IDLE;
        end
        default: begin
          if (func == FUNC_START) begin
            if (n == 3'd0) begin
              n = 3'd1;
            end
            if (n > 3'(MAX_MESSAGES)) begin
              n = 3'(MAX_MESSAGES);
            end
            act    = 1'b1;
            cm_nxt = '0;
            ml     = n;
            ap     = 1'b1;
            bp     = '0;
            wp_nxt = '0;
            fp     = 1'b0;
            fc     = '0;
            bl     = d.len;
          end
          if (!act) begin
            res.outcome = OUTC_IDLE;
          end else if ((item.ctrl_status & ST_ERRORS) != '0) begin
            act         = 1'b0;
            res.outcome = OUTC_ERROR;
          end else begin
            res.outcome = OUTC_RUNNING;
            if ((item.ctrl_status & ST_WR_FULL) == '0) begin
              if (ap) begin
                w = WORD_ADDR | {2'b00, d.addr, d.rd};
                if (ml == 3'd1 && d.len == 8'd0) begin
                  w = w | WORD_LAST;
                end
                res.data_write_valid = 1'b1;
                res.data_write_word  = w;
                ap = 1'b0;
              end else if (d.rd || bl == 8'd0) begin
                more_to_send = 1'b0;
              end else begin
                w = {2'b00, st_byte};
                if (bl == 8'd1 && ml == 3'd1) begin
                  w = w | WORD_LAST;
                end
                res.data_write_valid = 1'b1;
                res.data_write_word  = w;
                bp     = bp + 8'd1;
                bl     = bl - 8'd1;
                wp_nxt = wp_r + STORE_AW'(1);
              end
            end
            if ((item.ctrl_status & ST_RD_FULL) != '0) begin
              if (d.rd && !ap && bl != 8'd0) begin
                if (bl == 8'd2) begin
                  res.stop_write = 1'b1;
                end else if (bl == 8'd1 && bp == 8'd0) begin
                  fp             = 1'b1;
                  res.stop_write = 1'b1;
                end
                res.read_valid    = 1'b1;
                res.read_data     = item.read_byte_in;
                res.read_position = bp;
                res.read_message  = 2'(cm_nxt);
                bl = bl - 8'd1;
                bp = bp + 8'd1;
              end else begin
                if (fc[0]) begin
                  res.stop_write = 1'b1;
                end
                if (fp) begin
                  fp = 1'b0;
                end else begin
                  fc = fc + 8'd1;
                end
              end
            end
            if (!ap && bl == 8'd0) begin
              if (ml > 3'd1) begin
                ml     = ml - 3'd1;
                cm_nxt = cm_nxt + MSG_IW'(1);
                ap     = 1'b1;
                bp     = '0;
              end else if (!more_to_send && !fp) begin
                act         = 1'b0;
                res.outcome = OUTC_DONE;
              end
            end
          end
          active_nxt   = act;
          ml_nxt       = ml;
          ap_nxt       = ap;
          bp_nxt       = bp;
          bl_nxt       = bl;
          fp_nxt       = fp;
          fc_nxt       = fc;
          if (act && ap && bp == 8'd0 && ml != ml_r && func != FUNC_START) begin
            len_pend_nxt = 1'b1;
          end else if (act && ap && func == FUNC_START && ml != n) begin
            len_pend_nxt = 1'b1;
          end else begin
            len_pend_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_r[item.msg_index[MSG_IW-1:0]] <= desc_t'({item.msg_len, item.msg_read,
                                                     item.msg_addr});
    end
    fwd_data_r <= item.write_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      cm_r       <= '0;
      ml_r       <= '0;
      ap_r       <= 1'b1;
      bp_r       <= '0;
      bl_r       <= '0;
      len_pend_r <= 1'b0;
      wp_r       <= '0;
      fp_r       <= 1'b0;
      fc_r       <= '0;
      fwd_r      <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      cm_r       <= cm_nxt;
      ml_r       <= ml_nxt;
      ap_r       <= ap_nxt;
      bp_r       <= bp_nxt;
      bl_r       <= bl_nxt;
      len_pend_r <= len_pend_nxt;
      wp_r       <= wp_nxt;
      fp_r       <= fp_nxt;
      fc_r       <= fc_nxt;
      fwd_r      <= ram_we && (item.byte_index[STORE_AW-1:0] == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      if (in_acc) begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      out_data_r   <= skid_data_r;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_acc;
      out_data_r  <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r};

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import i2c_mts_pkg::*;

  localparam int ITEM_GOAL   = 1750;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  i2c_master_transfer_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Shadow copy of the sequencer state, advanced once per accepted item.
  logic                 seq_active = 1'b0;
  desc_t                desc_tab [MAX_MESSAGES];
  logic [7:0]           store_mem [STORE_DEPTH];
  bit                   store_written [STORE_DEPTH];
  logic [MSG_IW-1:0]    cur_msg = '0;
  logic [2:0]           msgs_left = '0;
  logic                 addr_pending = 1'b1;
  logic [7:0]           byte_pos = '0;
  logic [7:0]           bytes_left = '0;
  logic [STORE_AW-1:0]  wr_ptr = '0;
  logic                 flush_pend = 1'b0;
  logic [7:0]           flush_ctr = '0;

  result_t awaited_results [$];
  result_t got_res;
  result_t exp_res;
  string   diffs;

  bit steady = 1'b0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int transfers_done = 0;
  int transfers_failed = 0;
  int words_written = 0;
  int bytes_captured = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               awaited_results.size());
      $display("i2c_master_transfer_sequencer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 7);
  end

  function automatic result_t predict_item(input func_t f, input in_item_t it);
    result_t    r;
    desc_t      d;
    logic [9:0] w;
    logic [2:0] n;
    logic       more_to_send;
    r = '0;
    r.outcome = seq_active ? OUTC_RUNNING : OUTC_IDLE;
    if (f == FUNC_LOAD_DESC) begin
      desc_tab[it.msg_index] = {it.msg_len, it.msg_read, it.msg_addr};
    end else if (f == FUNC_LOAD_BYTE) begin
      store_mem[it.byte_index] = it.write_byte;
      store_written[it.byte_index] = 1'b1;
    end else begin
      if (f == FUNC_START) begin
        n = it.msg_count;
        if (n < 1) n = 3'd1;
        if (n > MAX_MESSAGES) n = 3'(MAX_MESSAGES);
        seq_active = 1'b1;
        cur_msg = '0;
        msgs_left = n;
        addr_pending = 1'b1;
        byte_pos = '0;
        wr_ptr = '0;
        flush_pend = 1'b0;
        flush_ctr = '0;
        bytes_left = desc_tab[0].len;
      end
      if (!seq_active) begin
        r.outcome = OUTC_IDLE;
      end else if ((it.ctrl_status & ST_ERRORS) != '0) begin
        seq_active = 1'b0;
        r.outcome = OUTC_ERROR;
      end else begin
        r.outcome = OUTC_RUNNING;
        d = desc_tab[cur_msg];
        more_to_send = 1'b1;
        if ((it.ctrl_status & ST_WR_FULL) == '0) begin
          if (addr_pending) begin
            w = WORD_ADDR | {2'b00, d.addr, d.rd};
            if (msgs_left == 1 && d.len == 0) w = w | WORD_LAST;
            r.data_write_valid = 1'b1;
            r.data_write_word = w;
            addr_pending = 1'b0;
          end else if (d.rd || bytes_left == 0) begin
            more_to_send = 1'b0;
          end else begin
            w = {2'b00, store_mem[wr_ptr]};
            if (bytes_left == 1 && msgs_left == 1) w = w | WORD_LAST;
            r.data_write_valid = 1'b1;
            r.data_write_word = w;
            byte_pos = byte_pos + 8'd1;
            bytes_left = bytes_left - 8'd1;
            wr_ptr = wr_ptr + STORE_AW'(1);
          end
        end
        if ((it.ctrl_status & ST_RD_FULL) != '0) begin
          if (d.rd && !addr_pending && bytes_left != 0) begin
            if (bytes_left == 2) begin
              r.stop_write = 1'b1;
            end else if (bytes_left == 1 && byte_pos == 0) begin
              flush_pend = 1'b1;
              r.stop_write = 1'b1;
            end
            r.read_valid = 1'b1;
            r.read_data = it.read_byte_in;
            r.read_position = byte_pos;
            r.read_message = cur_msg;
            bytes_left = bytes_left - 8'd1;
            byte_pos = byte_pos + 8'd1;
          end else begin
            if (flush_ctr[0]) r.stop_write = 1'b1;
            if (flush_pend) flush_pend = 1'b0;
            else flush_ctr = flush_ctr + 8'd1;
          end
        end
        if (!addr_pending && bytes_left == 0) begin
          if (msgs_left > 1) begin
            msgs_left = msgs_left - 3'd1;
            cur_msg = cur_msg + MSG_IW'(1);
            addr_pending = 1'b1;
            byte_pos = '0;
            bytes_left = desc_tab[cur_msg].len;
          end else if (!more_to_send && !flush_pend) begin
            seq_active = 1'b0;
            r.outcome = OUTC_DONE;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t random_fields();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[54:0];
  endfunction

  function automatic logic [9:0] clean_status();
    logic [31:0] r;
    r = $urandom;
    return {r[9:8], 6'b000000, r[1], r[7:4] < 4'd5};
  endfunction

  function automatic logic [7:0] pick_length();
    int k;
    k = $urandom_range(99);
    if (k < 80) return 8'($urandom_range(5));
    if (k < 95) return 8'($urandom_range(40, 6));
    return 8'($urandom_range(255, 200));
  endfunction

  task automatic send_item(input func_t f, input in_item_t it);
    result_t r;
    in_tuser <= f;
    in_tdata <= {1'b0, it.read_byte_in, it.ctrl_status, it.msg_count, it.write_byte,
                 it.byte_index, it.msg_len, it.msg_read, it.msg_addr, it.msg_index};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_item(f, it);
    awaited_results.push_back(r);
    items_sent++;
    if (r.outcome == OUTC_DONE) transfers_done++;
    if (r.outcome == OUTC_ERROR) transfers_failed++;
    if (r.data_write_valid) words_written++;
    if (r.read_valid) bytes_captured++;
    if (!steady && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // A status item may fetch the next write byte, so that entry is loaded first if unwritten.
  task automatic send_status(input logic [9:0] st);
    in_item_t it;
    if (!store_written[wr_ptr]) begin
      it = random_fields();
      it.byte_index = wr_ptr;
      send_item(FUNC_LOAD_BYTE, it);
    end
    it = random_fields();
    it.ctrl_status = st;
    send_item(FUNC_STATUS, it);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.data_write_valid = out_tdata[0];
      got_res.data_write_word  = out_tdata[10:1];
      got_res.stop_write       = out_tdata[11];
      got_res.read_valid       = out_tdata[12];
      got_res.read_data        = out_tdata[20:13];
      got_res.read_position    = out_tdata[28:21];
      got_res.read_message     = out_tdata[30:29];
      got_res.outcome          = outcome_t'(out_tdata[32:31]);
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("Result %0d arrived with nothing expected: %h",
                                  results_seen, got_res));
      end else begin
        exp_res = awaited_results.pop_front();
        diffs = "";
        if (got_res.data_write_valid !== exp_res.data_write_valid)
          diffs = {diffs, " data_write_valid"};
        if (got_res.data_write_word !== exp_res.data_write_word)
          diffs = {diffs, " data_write_word"};
        if (got_res.stop_write !== exp_res.stop_write) diffs = {diffs, " stop_write"};
        if (got_res.read_valid !== exp_res.read_valid) diffs = {diffs, " read_valid"};
        if (got_res.read_data !== exp_res.read_data) diffs = {diffs, " read_data"};
        if (got_res.read_position !== exp_res.read_position)
          diffs = {diffs, " read_position"};
        if (got_res.read_message !== exp_res.read_message) diffs = {diffs, " read_message"};
        if (got_res.outcome !== exp_res.outcome) diffs = {diffs, " outcome"};
        if (diffs != "")
          report_mismatch($sformatf("Result %0d differs in%s: expected %h, got %h",
                                    results_seen, diffs, exp_res, got_res));
      end
    end
  end

  task automatic test_idle_and_loads();
    in_item_t it;
    it = random_fields();
    it.ctrl_status = 10'h3ff;
    send_item(FUNC_STATUS, it);
    it = random_fields();
    it.msg_index = 2'd0; it.msg_addr = 7'h7f; it.msg_read = 1'b0; it.msg_len = 8'd2;
    send_item(FUNC_LOAD_DESC, it);
    it.msg_index = 2'd1; it.msg_addr = 7'h00; it.msg_read = 1'b1; it.msg_len = 8'd1;
    send_item(FUNC_LOAD_DESC, it);
    it.msg_index = 2'd2; it.msg_addr = 7'h55; it.msg_read = 1'b1; it.msg_len = 8'd2;
    send_item(FUNC_LOAD_DESC, it);
    it.msg_index = 2'd3; it.msg_addr = 7'h2a; it.msg_read = 1'b0; it.msg_len = 8'd0;
    send_item(FUNC_LOAD_DESC, it);
    it.byte_index = 8'd0; it.write_byte = 8'hff;
    send_item(FUNC_LOAD_BYTE, it);
    it.byte_index = 8'd1; it.write_byte = 8'h00;
    send_item(FUNC_LOAD_BYTE, it);
    it.byte_index = 8'd255; it.write_byte = 8'ha5;
    send_item(FUNC_LOAD_BYTE, it);
  endtask

  // A zero message count is raised to one; the write message ends on its last byte.
  task automatic test_single_write();
    in_item_t it;
    it = random_fields();
    it.msg_count = 3'd0;
    it.ctrl_status = 10'h000;
    send_item(FUNC_START, it);
    repeat (3) send_status(10'h000);
  endtask

  // All four slots: write, single-byte read, two-byte read and an empty last write,
  // with the read buffer always full so that flushes and stops occur.
  task automatic test_mixed_messages();
    in_item_t it;
    int       steps;
    it = random_fields();
    it.msg_count = 3'd7;
    it.ctrl_status = ST_RD_FULL | 10'h300;
    send_item(FUNC_START, it);
    steps = 0;
    while (seq_active && steps < 20) begin
      send_status(ST_RD_FULL);
      steps++;
    end
  endtask

  task automatic test_error_and_restart();
    in_item_t it;
    it = random_fields();
    it.msg_count = 3'd1;
    it.ctrl_status = 10'h004;
    send_item(FUNC_START, it);
    it.ctrl_status = 10'h0f8;
    send_item(FUNC_STATUS, it);
    it.msg_count = 3'd5;
    it.ctrl_status = ST_WR_FULL;
    send_item(FUNC_START, it);
    it.msg_count = 3'd2;
    send_item(FUNC_START, it);
  endtask

  task automatic test_random_traffic();
    in_item_t    it;
    logic [31:0] r;
    int          k;
    int          steps;
    bit          noisy;
    while (items_sent < ITEM_GOAL) begin
      steady = (items_sent >= 700 && items_sent < 1100);
      noisy = ($urandom_range(3) == 0);
      if ($urandom_range(9) < 3) begin
        repeat ($urandom_range(3, 1)) begin
          it = random_fields();
          it.msg_len = pick_length();
          send_item(FUNC_LOAD_DESC, it);
        end
      end
      if ($urandom_range(9) < 2)
        repeat ($urandom_range(4, 1)) send_item(FUNC_LOAD_BYTE, random_fields());
      it = random_fields();
      if ($urandom_range(9) < 8) it.msg_count = 3'($urandom_range(MAX_MESSAGES, 1));
      if (!noisy) it.ctrl_status = clean_status();
      send_item(FUNC_START, it);
      steps = 0;
      while (seq_active && steps < 700 && items_sent < ITEM_GOAL) begin
        k = $urandom_range(99);
        r = $urandom;
        if (noisy && k < 3) begin
          send_status(r[9:0]);
        end else if (k < 5) begin
          it = random_fields();
          it.msg_len = pick_length();
          case ($urandom_range(9))
            0: send_item(FUNC_START, it);
            1, 2, 3, 4: send_item(FUNC_LOAD_DESC, it);
            default: send_item(FUNC_LOAD_BYTE, it);
          endcase
        end else begin
          send_status(clean_status());
        end
        steps++;
      end
      if ($urandom_range(4) == 0) begin
        it = random_fields();
        send_status(it.ctrl_status);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_loads();
    test_single_write();
    test_mixed_messages();
    test_error_and_restart();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items and checked %0d results.", items_sent, results_seen);
    $display("%0d transfers completed and %0d ended in error; %0d words written, %0d %s",
             transfers_done, transfers_failed, words_written, bytes_captured,
             "read bytes captured.");
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("i2c_master_transfer_sequencer verification clean");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("i2c_master_transfer_sequencer verification failed");
    end
    $finish;
  end

endmodule
